FILE: rtl/tdcs_pkg.sv
// Shared types and codes for the tank drive command shaper.
// Holds the sequencer state type, mode, action and register index codes.
// No dependencies.
package tdcs_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_STRAIGHT_SPEED  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TURN_SPEED      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TURN_GAIN       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_FACTOR     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CUBIC_WEIGHT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND_OFFSET = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE_LOCKOUT   = 3'd6;

  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_TELEOP   = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [2:0] ACT_STOP          = 3'd0;
  localparam logic [2:0] ACT_FORWARD       = 3'd1;
  localparam logic [2:0] ACT_BACK          = 3'd2;
  localparam logic [2:0] ACT_TURN_FWD_RGT  = 3'd3;
  localparam logic [2:0] ACT_TURN_FWD_LFT  = 3'd4;
  localparam logic [2:0] ACT_TURN_BACK_RGT = 3'd5;
  localparam logic [2:0] ACT_TURN_BACK_LFT = 3'd6;

  localparam int TICK_W = 16;
  localparam logic [TICK_W-1:0] LOCKOUT_RESET = 16'd4500;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOW,
    ST_SQR,
    ST_CUBE,
    ST_WCUB,
    ST_WLIN,
    ST_OFFS,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/tank_drive_command_shaper.sv
// Tank drive command shaper: one control tick in, one motor/valve word out. Depends on tdcs_pkg.
// Disabled, autonomous and idle-mode ticks go from input accept straight to the output state;
// teleop ticks first run the shared multiply sequence (five shared products per
// stick, six with slow scaling, two sticks in turn). The next word is taken the cycle after
// the result is registered, so no new tick is taken while one is in flight; a waiting result holds the next one.
// Reset (rst_n low, synchronous) releases the brake, clears button history and ticks, and restores register defaults.
module tank_drive_command_shaper
  import tdcs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  localparam int CFG_W = (SAMPLE_BITS > TICK_W) ? SAMPLE_BITS : TICK_W
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_W-1:0]              cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [2:0]                    in_auto_action,
  input  logic signed [SAMPLE_BITS-1:0] in_left_stick,
  input  logic signed [SAMPLE_BITS-1:0] in_right_stick,
  input  logic                          in_slow_button,
  input  logic                          in_brake_button,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_drive,
  output logic signed [SAMPLE_BITS-1:0] out_right_drive,
  output logic                          out_motor_update,
  output logic                          out_brake_on,
  output logic                          out_valve_update
);

  localparam int SB = SAMPLE_BITS;
  localparam int F  = SB - 1;
  localparam int PW = 2 * SB;

  localparam logic [SB-1:0] ONE   = {1'b1, {F{1'b0}}};
  localparam logic [SB-1:0] MAXV  = {1'b0, {F{1'b1}}};
  localparam logic [SB-1:0] HALFV = {2'b01, {(F-1){1'b0}}};
  localparam logic [PW-1:0] HALF  = {{(SB+1){1'b0}}, 1'b1, {(F-1){1'b0}}};

  function automatic logic [SB-1:0] sat_to(input logic [SB-1:0] v, input logic [SB-1:0] hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [SB-1:0] enc(input logic neg, input logic [SB-1:0] mag);
    return neg ? ({SB{1'b0}} - mag) : mag;
  endfunction

  // configuration, saturated on write except the brake lockout
  logic [SB-1:0]     straight_r, turn_r, gain_r, slow_f_r, cubic_r, dead_r;
  logic [TICK_W-1:0] lock_r;
  logic [SB-1:0]     cfg_v;

  assign cfg_v = cfg_data[SB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      straight_r <= HALFV;
      turn_r     <= HALFV;
      gain_r     <= '0;
      slow_f_r   <= HALFV;
      cubic_r    <= HALFV;
      dead_r     <= '0;
      lock_r     <= LOCKOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STRAIGHT_SPEED:  straight_r <= sat_to(cfg_v, MAXV);
        CFG_TURN_SPEED:      turn_r     <= sat_to(cfg_v, MAXV);
        CFG_TURN_GAIN:       gain_r     <= sat_to(cfg_v, MAXV);
        CFG_SLOW_FACTOR:     slow_f_r   <= sat_to(cfg_v, ONE);
        CFG_CUBIC_WEIGHT:    cubic_r    <= sat_to(cfg_v, ONE);
        CFG_DEADBAND_OFFSET: dead_r     <= sat_to(cfg_v, MAXV);
        CFG_BRAKE_LOCKOUT:   lock_r     <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t            state_r, state_nxt;
  logic              brake_r, brake_nxt;
  logic              last_r, last_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [1:0]        mode_r, mode_nxt;
  logic [2:0]        act_r, act_nxt;
  logic              slow_r, slow_nxt;
  logic              btn_r, btn_nxt;
  logic              stick_r, stick_nxt;
  logic [SB-1:0]     mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [SB-1:0]     rmag_r, rmag_nxt;
  logic              rneg_r, rneg_nxt;
  logic [SB-1:0]     m_r, m_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [SB-1:0]     lres_r, lres_nxt;
  logic [SB-1:0]     rres_r, rres_nxt;

  logic [SB-1:0]     ld_r, ld_nxt, rd_r, rd_nxt;
  logic              mu_r, mu_nxt, bo_r, bo_nxt, vu_r, vu_nxt;

  // shared multiply and round unit
  logic [SB-1:0] mul_a, mul_b;
  logic [PW-1:0] prod, addend, rsum;
  logic [SB-1:0] rnd_val;
  logic [SB:0]   c_sum;
  logic [SB-1:0] c_sat, drive;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    unique case (state_r)
      ST_SLOW: begin
        mul_a = mag_r;
        mul_b = slow_f_r;
      end
      ST_SQR: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      ST_CUBE: begin
        mul_a = m_r;
        mul_b = mag_r;
      end
      ST_WCUB: begin
        mul_a = cubic_r;
        mul_b = m_r;
      end
      ST_WLIN: begin
        mul_a  = ONE - cubic_r;
        mul_b  = mag_r;
        addend = acc_r;
      end
      ST_OFFS: begin
        mul_a = ONE - dead_r;
        mul_b = m_r;
      end
      ST_IDLE, ST_OUT: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign rsum    = prod + addend + HALF;
  assign rnd_val = rsum[F +: SB];
  assign c_sum   = {1'b0, dead_r} + {1'b0, rnd_val};
  assign c_sat   = (c_sum > {1'b0, MAXV}) ? MAXV : c_sum[SB-1:0];
  // a stick scaled down to zero counts as positive
  assign drive   = enc(neg_r && (mag_r != '0), c_sat);

  // input magnitudes: left is negated, right is taken as is
  logic [SB-1:0] ls_u, rs_u, ls_abs, rs_abs, lmag_in, rmag_in;
  logic          lneg_in;

  assign ls_u    = in_left_stick;
  assign rs_u    = in_right_stick;
  assign ls_abs  = {SB{1'b0}} - ls_u;
  assign rs_abs  = {SB{1'b0}} - rs_u;
  assign lneg_in = !ls_u[F] && (ls_u != '0);
  assign lmag_in = ls_u[F] ? sat_to(ls_abs, MAXV) : ls_u;
  assign rmag_in = rs_u[F] ? rs_abs : rs_u;

  // autonomous speeds
  logic [SB:0]   tg_sum;
  logic [SB-1:0] tg;
  logic          toggle;

  assign tg_sum = {1'b0, turn_r} + {1'b0, gain_r};
  assign tg     = (tg_sum > {1'b0, MAXV}) ? MAXV : tg_sum[SB-1:0];
  assign toggle = btn_r && !last_r && (ticks_r >= lock_r);

  always_comb begin
    state_nxt     = state_r;
    brake_nxt     = brake_r;
    last_nxt      = last_r;
    ticks_nxt     = ticks_r;
    out_valid_nxt = out_valid_r && out_stall;
    mode_nxt      = mode_r;
    act_nxt       = act_r;
    slow_nxt      = slow_r;
    btn_nxt       = btn_r;
    stick_nxt     = stick_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rmag_nxt      = rmag_r;
    rneg_nxt      = rneg_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    lres_nxt      = lres_r;
    rres_nxt      = rres_r;
    ld_nxt        = ld_r;
    rd_nxt        = rd_r;
    mu_nxt        = mu_r;
    bo_nxt        = bo_r;
    vu_nxt        = vu_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          act_nxt   = in_auto_action;
          slow_nxt  = in_slow_button;
          btn_nxt   = in_brake_button;
          stick_nxt = 1'b0;
          mag_nxt   = lmag_in;
          neg_nxt   = lneg_in;
          rmag_nxt  = rmag_in;
          rneg_nxt  = rs_u[F];
          if (in_mode == MODE_TELEOP) begin
            state_nxt = in_slow_button ? ST_SLOW : ST_SQR;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SLOW: begin
        mag_nxt   = rnd_val;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        m_nxt     = rnd_val;
        state_nxt = ST_CUBE;
      end
      ST_CUBE: begin
        m_nxt     = rnd_val;
        state_nxt = ST_WCUB;
      end
      ST_WCUB: begin
        // hold the unrounded cubic product for the mix step
        acc_nxt   = prod;
        state_nxt = ST_WLIN;
      end
      ST_WLIN: begin
        m_nxt     = rnd_val;
        state_nxt = ST_OFFS;
      end
      ST_OFFS: begin
        if (!stick_r) begin
          lres_nxt  = drive;
          mag_nxt   = rmag_r;
          neg_nxt   = rneg_r;
          stick_nxt = 1'b1;
          state_nxt = slow_r ? ST_SLOW : ST_SQR;
        end else begin
          rres_nxt  = drive;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          ld_nxt        = '0;
          rd_nxt        = '0;
          mu_nxt        = 1'b0;
          vu_nxt        = 1'b0;
          bo_nxt        = brake_r;
          unique case (mode_r)
            MODE_DISABLED: begin
              brake_nxt = 1'b0;
              last_nxt  = 1'b0;
              ticks_nxt = '0;
              bo_nxt    = 1'b0;
            end
            MODE_AUTO: begin
              mu_nxt = 1'b1;
              // right motor is mirrored: forward drives it negative
              unique case (act_r)
                ACT_FORWARD: begin
                  ld_nxt = enc(1'b0, straight_r);
                  rd_nxt = enc(1'b1, straight_r);
                end
                ACT_BACK: begin
                  ld_nxt = enc(1'b1, straight_r);
                  rd_nxt = enc(1'b0, straight_r);
                end
                ACT_TURN_FWD_RGT: begin
                  ld_nxt = enc(1'b0, turn_r);
                  rd_nxt = enc(1'b1, tg);
                end
                ACT_TURN_FWD_LFT: begin
                  ld_nxt = enc(1'b0, tg);
                  rd_nxt = enc(1'b1, turn_r);
                end
                ACT_TURN_BACK_RGT: begin
                  ld_nxt = enc(1'b1, turn_r);
                  rd_nxt = enc(1'b0, tg);
                end
                ACT_TURN_BACK_LFT: begin
                  ld_nxt = enc(1'b1, tg);
                  rd_nxt = enc(1'b0, turn_r);
                end
                default: ;
              endcase
            end
            MODE_TELEOP: begin
              brake_nxt = brake_r ^ toggle;
              last_nxt  = btn_r;
              if (ticks_r != TICK_MAX) begin
                ticks_nxt = ticks_r + 1'b1;
              end
              vu_nxt = 1'b1;
              bo_nxt = brake_r ^ toggle;
              if (!(brake_r ^ toggle)) begin
                mu_nxt = 1'b1;
                ld_nxt = lres_r;
                rd_nxt = rres_r;
              end
            end
            MODE_NONE: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      brake_r     <= 1'b0;
      last_r      <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brake_r     <= brake_nxt;
      last_r      <= last_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    act_r   <= act_nxt;
    slow_r  <= slow_nxt;
    btn_r   <= btn_nxt;
    stick_r <= stick_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    rmag_r  <= rmag_nxt;
    rneg_r  <= rneg_nxt;
    m_r     <= m_nxt;
    acc_r   <= acc_nxt;
    lres_r  <= lres_nxt;
    rres_r  <= rres_nxt;
    ld_r    <= ld_nxt;
    rd_r    <= rd_nxt;
    mu_r    <= mu_nxt;
    bo_r    <= bo_nxt;
    vu_r    <= vu_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_left_drive   = ld_r;
  assign out_right_drive  = rd_r;
  assign out_motor_update = mu_r;
  assign out_brake_on     = bo_r;
  assign out_valve_update = vu_r;

endmodule
